// ===== rtl/unpremultiply_linear_to_srgb8_top_defines.svh =====
// ----------------------------------------------------------------------------
// unpremultiply_linear_to_srgb8 assertion macros
// shared concurrent assertion forms for the rtl files
// ----------------------------------------------------------------------------
`ifndef UNPREMULTIPLY_LINEAR_TO_SRGB8_TOP_DEFINES_SVH
`define UNPREMULTIPLY_LINEAR_TO_SRGB8_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// antecedent in a cycle implies consequent in the same cycle
`define ULS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// condition must hold in every cycle out of reset
`define ULS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
	else $error("assertion failed");
`else
`define ULS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ULS_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/ulsrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// ulsrgb_pkg
// shared types, constants and the srgb decision threshold table
// ----------------------------------------------------------------------------
package ulsrgb_pkg;

	localparam int QW = 17;
	typedef logic [QW-1:0] q_t;
	typedef logic [31:0] fp_t;
	typedef logic [7:0] byte_t;
	typedef q_t thr_tab_t [256];

	localparam q_t Q_ONE = 17'h10000;
	localparam fp_t ALPHA_FLOOR = 32'h358637BD;
	localparam int DIV_BITS = 18;
	localparam int WIDE = 320;

	typedef logic [WIDE-1:0] wide_t;

	function automatic thr_tab_t build_thresh();
		thr_tab_t tab;
		wide_t den12;
		wide_t rhs;
		wide_t lhs;
		int lo;
		int hi;
		int mid;
		tab = '{default: '0};
		den12 = wide_t'(1);
		for (int i = 0; i < 12; i++) den12 = den12 * wide_t'(10761);
		for (int k = 1; k <= 10; k++) begin
			tab[k] = q_t'(((longint'(2 * k - 1) * 64'd6553600) + 64'd658919) / 64'd658920);
		end
		for (int k = 11; k <= 255; k++) begin
			rhs = wide_t'(1);
			for (int i = 0; i < 12; i++) rhs = rhs * wide_t'(40 * k + 541);
			rhs = rhs << 80;
			lo = 206;
			hi = 65536;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				lhs = den12;
				for (int i = 0; i < 5; i++) lhs = lhs * wide_t'(mid);
				if (lhs >= rhs) hi = mid;
				else lo = mid + 1;
			end
			tab[k] = q_t'(lo);
		end
		return tab;
	endfunction

	localparam thr_tab_t THRESH = build_thresh();

endpackage

// ===== rtl/unpremultiply_linear_to_srgb8_top.sv =====
// ----------------------------------------------------------------------------
// unpremultiply_linear_to_srgb8_top
// premultiplied linear float rgba pixel to srgb bytes, blue green red
// ----------------------------------------------------------------------------
// usage:
// a pixel transfer happens at a rising edge with start high and busy low.
// busy is always low, so a new pixel may be given on every clock.
// fields red_linear, green_linear, blue_linear, alpha_cover are ieee single
// bit patterns; alpha is floored at 1e-6 before the divide.
// done is high for exactly one cycle with blue_byte, green_byte, red_byte;
// the result transfer happens at the edge that ends that cycle.
// a pixel passes through five divider/clamp stages (18-bit restoring divide,
// six bits per stage) and then four table search stages (two threshold
// compares per stage).
// throughput: one pixel per clock, sustained.
// reset clears all valid bits; no result appears until a pixel is taken.
// the receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module unpremultiply_linear_to_srgb8_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ulsrgb_pkg::fp_t   red_linear,
	input  ulsrgb_pkg::fp_t   green_linear,
	input  ulsrgb_pkg::fp_t   blue_linear,
	input  ulsrgb_pkg::fp_t   alpha_cover,
	output logic              done,
	output ulsrgb_pkg::byte_t blue_byte,
	output ulsrgb_pkg::byte_t green_byte,
	output ulsrgb_pkg::byte_t red_byte
);
	import ulsrgb_pkg::*;

	fp_t alpha_f;
	logic a_nan;
	logic take;
	logic vq_b, vq_g, vq_r, ve_b, ve_g, ve_r;
	q_t q_b, q_g, q_r;

	assign busy = 1'b0;
	assign take = start && !busy;

	always_comb begin
		a_nan = (alpha_cover[30:23] == 8'hFF) && (alpha_cover[22:0] != '0);
		if (alpha_cover[31] || a_nan || alpha_cover < ALPHA_FLOOR) alpha_f = ALPHA_FLOOR;
		else alpha_f = alpha_cover;
	end

	ulsrgb_quot u_quot_b (.clk, .arst_n, .valid_in(take), .chan(blue_linear),
		.alpha(alpha_f), .valid_out(vq_b), .q(q_b));
	ulsrgb_quot u_quot_g (.clk, .arst_n, .valid_in(take), .chan(green_linear),
		.alpha(alpha_f), .valid_out(vq_g), .q(q_g));
	ulsrgb_quot u_quot_r (.clk, .arst_n, .valid_in(take), .chan(red_linear),
		.alpha(alpha_f), .valid_out(vq_r), .q(q_r));

	ulsrgb_enc u_enc_b (.clk, .arst_n, .valid_in(vq_b), .q(q_b),
		.valid_out(ve_b), .code(blue_byte));
	ulsrgb_enc u_enc_g (.clk, .arst_n, .valid_in(vq_g), .q(q_g),
		.valid_out(ve_g), .code(green_byte));
	ulsrgb_enc u_enc_r (.clk, .arst_n, .valid_in(vq_r), .q(q_r),
		.valid_out(ve_r), .code(red_byte));

	assign done = ve_b & ve_g & ve_r;
endmodule

// ===== rtl/ulsrgb_quot.sv =====
// ----------------------------------------------------------------------------
// ulsrgb_quot
// channel over alpha in q1.16, restoring divider over three stages
// ----------------------------------------------------------------------------
`include "unpremultiply_linear_to_srgb8_top_defines.svh"

module ulsrgb_quot (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	input  ulsrgb_pkg::fp_t    chan,
	input  ulsrgb_pkg::fp_t    alpha,
	output logic               valid_out,
	output ulsrgb_pkg::q_t     q
);
	import ulsrgb_pkg::*;

	logic [7:0] ce, ae;
	logic [22:0] cf;
	logic signed [9:0] e;
	logic zero_c, sat_c;
	logic [4:0] sh_c;

	always_comb begin
		ce = chan[30:23];
		cf = chan[22:0];
		ae = alpha[30:23];
		e = $signed({2'b00, ce}) - $signed({2'b00, ae});
		zero_c = 1'b0;
		sat_c = 1'b0;
		if ((ce == 8'hFF && cf != '0) || chan[31]) zero_c = 1'b1;
		else if (ce == 8'hFF) begin
			if (ae == 8'hFF) zero_c = 1'b1;
			else sat_c = 1'b1;
		end else if (ae == 8'hFF || ce == 8'h00) zero_c = 1'b1;
		else if (e >= 10'sd1) sat_c = 1'b1;
		else if (e <= -10'sd18) zero_c = 1'b1;
		sh_c = 5'(10'sd1 - e);
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic zero_s1, zero_s2, zero_s3, zero_s4;
	logic sat_s1, sat_s2, sat_s3, sat_s4;
	logic [4:0] sh_s1, sh_s2, sh_s3, sh_s4;
	logic [23:0] am_s1, am_s2, am_s3;
	logic [24:0] rem_s1, rem_s2, rem_s3;
	logic [DIV_BITS-1:0] x_s2, x_s3, x_s4;
	q_t q_s5;

	// six quotient bits per call; the very first bit takes no shift
	function automatic void div6(input logic [24:0] rin, input logic [23:0] am,
		input logic first, output logic [24:0] rout, output logic [5:0] bits);
		logic [24:0] r;
		r = rin;
		for (int i = 0; i < 6; i++) begin
			if (!(first && i == 0)) r = {r[23:0], 1'b0};
			if (r >= {1'b0, am}) begin
				bits[5-i] = 1'b1;
				r = r - {1'b0, am};
			end else begin
				bits[5-i] = 1'b0;
			end
		end
		rout = r;
	endfunction

	logic [24:0] r2_c, r3_c, r4_c;
	logic [5:0] b2_c, b3_c, b4_c;
	logic [DIV_BITS-1:0] sx_c;
	q_t q_c;

	always_comb begin
		div6(rem_s1, am_s1, 1'b1, r2_c, b2_c);
		div6(rem_s2, am_s2, 1'b0, r3_c, b3_c);
		div6(rem_s3, am_s3, 1'b0, r4_c, b4_c);
		sx_c = x_s4 >> sh_s4;
		if (zero_s4) q_c = '0;
		else if (sat_s4 || sx_c >= DIV_BITS'(Q_ONE)) q_c = Q_ONE;
		else q_c = q_t'(sx_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= zero_c;
		sat_s1 <= sat_c;
		sh_s1 <= sh_c;
		am_s1 <= {1'b1, alpha[22:0]};
		rem_s1 <= {2'b01, cf};
		zero_s2 <= zero_s1;
		sat_s2 <= sat_s1;
		sh_s2 <= sh_s1;
		am_s2 <= am_s1;
		rem_s2 <= r2_c;
		x_s2 <= {b2_c, 12'b0};
		zero_s3 <= zero_s2;
		sat_s3 <= sat_s2;
		sh_s3 <= sh_s2;
		am_s3 <= am_s2;
		rem_s3 <= r3_c;
		x_s3 <= {x_s2[17:12], b3_c, 6'b0};
		zero_s4 <= zero_s3;
		sat_s4 <= sat_s3;
		sh_s4 <= sh_s3;
		x_s4 <= {x_s3[17:6], b4_c};
		q_s5 <= q_c;
	end

	assign valid_out = v_s5;
	assign q = q_s5;

	`ULS_ASSERT_IMP(a_q_range, clk, arst_n, v_s5, q_s5 <= Q_ONE)
	`ULS_ASSERT_IMP(a_rem_bound, clk, arst_n, v_s4, rem_s3 < {1'b0, am_s3})
endmodule

// ===== rtl/ulsrgb_enc.sv =====
// ----------------------------------------------------------------------------
// ulsrgb_enc
// srgb byte from q1.16 by binary search of the threshold table
// ----------------------------------------------------------------------------
`include "unpremultiply_linear_to_srgb8_top_defines.svh"

module ulsrgb_enc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	input  ulsrgb_pkg::q_t     q,
	output logic               valid_out,
	output ulsrgb_pkg::byte_t  code
);
	import ulsrgb_pkg::*;

	// two search bits per stage, msb first
	function automatic byte_t srch2(input byte_t n, input q_t qv, input int b);
		byte_t r;
		byte_t t;
		r = n;
		for (int i = 0; i < 2; i++) begin
			t = r | (byte_t'(1) << (b - i));
			if (qv >= THRESH[t]) r = t;
		end
		return r;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;
	q_t q_s1, q_s2, q_s3;
	byte_t n_s1, n_s2, n_s3, n_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		q_s1 <= q;
		n_s1 <= srch2('0, q, 7);
		q_s2 <= q_s1;
		n_s2 <= srch2(n_s1, q_s1, 5);
		q_s3 <= q_s2;
		n_s3 <= srch2(n_s2, q_s2, 3);
		n_s4 <= srch2(n_s3, q_s3, 1);
	end

	assign valid_out = v_s4;
	assign code = n_s4;

	`ULS_ASSERT_IMP(a_full_scale, clk, arst_n, v_s4 && $past(q, 4) == Q_ONE, n_s4 == 8'hFF)
	`ULS_ASSERT_IMP(a_black, clk, arst_n, v_s4 && $past(q, 4) == '0, n_s4 == 8'h00)
	`ULS_ASSERT_ALWAYS(a_valid_flow, clk, arst_n, v_s4 == $past(v_s3))
endmodule

// ===== tb/unpremultiply_linear_to_srgb8_checker.sv =====
// ----------------------------------------------------------------------------
// unpremultiply_linear_to_srgb8 checker
// watches pixel and result transfers, predicts the srgb bytes of each pixel
// and compares every result against the oldest pending prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module unpremultiply_linear_to_srgb8_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  ulsrgb_pkg::fp_t   red_linear,
	input  ulsrgb_pkg::fp_t   green_linear,
	input  ulsrgb_pkg::fp_t   blue_linear,
	input  ulsrgb_pkg::fp_t   alpha_cover,
	input  logic              done,
	input  ulsrgb_pkg::byte_t blue_byte,
	input  ulsrgb_pkg::byte_t green_byte,
	input  ulsrgb_pkg::byte_t red_byte,
	output int                errors,
	output int                pending,
	output int                pixels_seen
);
	import ulsrgb_pkg::*;

	typedef struct packed {
		byte_t b;
		byte_t g;
		byte_t r;
	} bgr_t;

	localparam logic [31:0] ONE_Q = 32'd65536;

	logic [16:0] level [1:255];
	bgr_t        bgr_fifo [$];

	// smallest q with 1.055*(q/65536)^(1/2.4)-0.055 >= (k-0.5)/255, found exactly
	function automatic logic pow_ok(int q, logic [319:0] d12, logic [319:0] goal);
		logic [319:0] acc;
		acc = d12;
		repeat (5) acc = acc * 320'(q);
		return acc >= goal;
	endfunction

	initial begin
		logic [319:0] d12;
		logic [319:0] goal;
		int lo;
		int hi;
		int mid;
		d12 = 320'd1;
		repeat (12) d12 = d12 * 320'd10761;
		for (int k = 1; k <= 10; k++)
			level[k] = 17'((64'(2 * k - 1) * 64'd6553600 + 64'd658919) / 64'd658920);
		lo = 206;
		for (int k = 11; k <= 255; k++) begin
			goal = 320'd1;
			repeat (12) goal = goal * 320'(40 * k + 541);
			goal = goal << 80;
			hi = 65536;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (pow_ok(mid, d12, goal)) hi = mid;
				else lo = mid + 1;
			end
			level[k] = 17'(lo);
		end
	end

	function automatic logic [31:0] unpremul_q(fp_t c, fp_t a);
		logic [7:0]  ce;
		logic [7:0]  ae;
		logic [63:0] cm;
		logic [63:0] am;
		logic [63:0] quo;
		int          sh;
		ce = c[30:23];
		ae = a[30:23];
		if (ce == 8'hFF && c[22:0] != 0) return 0;
		if (c[31]) return 0;
		if (ce == 8'hFF) return (ae == 8'hFF) ? 0 : ONE_Q;
		if (ae == 8'hFF) return 0;
		if (c[30:0] == 0) return 0;
		cm = (ce == 0) ? 64'(c[22:0]) : 64'({1'b1, c[22:0]});
		am = 64'({1'b1, a[22:0]});
		sh = ((ce == 0) ? -149 : int'(ce) - 150) - (int'(ae) - 150) + 16;
		if (sh >= 40) return ONE_Q;
		if (sh <= -40) return 0;
		if (sh >= 0) quo = (cm << sh) / am;
		else quo = cm / (am << (-sh));
		return (quo >= 64'(ONE_Q)) ? ONE_Q : quo[31:0];
	endfunction

	function automatic byte_t srgb_byte(logic [31:0] q);
		int n;
		n = 0;
		for (int k = 1; k <= 255; k++)
			if (q >= 32'(level[k])) n++;
		return byte_t'(n);
	endfunction

	function automatic bgr_t predict_bgr(fp_t r, fp_t g, fp_t b, fp_t a);
		bgr_t o;
		if (a[31] || (a[30:23] == 8'hFF && a[22:0] != 0) || a < ALPHA_FLOOR)
			a = ALPHA_FLOOR;
		o.b = srgb_byte(unpremul_q(b, a));
		o.g = srgb_byte(unpremul_q(g, a));
		o.r = srgb_byte(unpremul_q(r, a));
		return o;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		pixels_seen = 0;
	end

	always @(posedge clk) begin
		bgr_t want;
		if (arst_n) begin
			if (done) begin
				if (bgr_fifo.size() == 0) begin
					$display("%0t: result with nothing pending: got b=%0d g=%0d r=%0d",
						$time, blue_byte, green_byte, red_byte);
					errors = errors + 1;
				end else begin
					want = bgr_fifo.pop_front();
					if (want.b !== blue_byte) begin
						$display("%0t: blue_byte expected %0d actual %0d",
							$time, want.b, blue_byte);
						errors = errors + 1;
					end
					if (want.g !== green_byte) begin
						$display("%0t: green_byte expected %0d actual %0d",
							$time, want.g, green_byte);
						errors = errors + 1;
					end
					if (want.r !== red_byte) begin
						$display("%0t: red_byte expected %0d actual %0d",
							$time, want.r, red_byte);
						errors = errors + 1;
					end
				end
			end
			if (start && !busy) begin
				bgr_fifo = {bgr_fifo, predict_bgr(red_linear, green_linear, blue_linear,
					alpha_cover)};
				pixels_seen = pixels_seen + 1;
			end
			pending = bgr_fifo.size();
		end
	end

endmodule

// ===== tb/unpremultiply_linear_to_srgb8_top_tb.sv =====
// ----------------------------------------------------------------------------
// unpremultiply_linear_to_srgb8 testbench
// directed corner pixels then random pixels under several sender idle
// patterns; the checker predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module unpremultiply_linear_to_srgb8_top_tb;
	import ulsrgb_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	fp_t   red_linear;
	fp_t   green_linear;
	fp_t   blue_linear;
	fp_t   alpha_cover;
	logic  done;
	byte_t blue_byte;
	byte_t green_byte;
	byte_t red_byte;
	int    errors;
	int    pending;
	int    pixels_seen;
	int    quiet_cycles;
	int    idle_pct;

	unpremultiply_linear_to_srgb8_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.red_linear(red_linear), .green_linear(green_linear),
		.blue_linear(blue_linear), .alpha_cover(alpha_cover),
		.done(done), .blue_byte(blue_byte), .green_byte(green_byte),
		.red_byte(red_byte)
	);

	unpremultiply_linear_to_srgb8_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.red_linear(red_linear), .green_linear(green_linear),
		.blue_linear(blue_linear), .alpha_cover(alpha_cover),
		.done(done), .blue_byte(blue_byte), .green_byte(green_byte),
		.red_byte(red_byte), .errors(errors), .pending(pending),
		.pixels_seen(pixels_seen)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// cycles with no transfer on either side
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired at %0t", $time);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// called at a falling edge; drive one pixel and hold it until transferred
	task automatic send_pixel(fp_t r, fp_t g, fp_t b, fp_t a);
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		red_linear = r;
		green_linear = g;
		blue_linear = b;
		alpha_cover = a;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start = 1'b0;
	endtask

	function automatic fp_t special_fp();
		case ($urandom_range(0, 11))
			0: return 32'h00000000;
			1: return 32'h80000000;
			2: return 32'h7F800000;
			3: return 32'hFF800000;
			4: return 32'h7FC00000 | 32'($urandom_range(0, 32'h3FFFFF));
			5: return 32'h3F800000;
			6: return 32'(($urandom_range(1, 32'h7FFFFF)));
			7: return 32'h358637BD;
			8: return 32'h358637BC;
			9: return 32'h3B4D2E1C;
			10: return 32'hFFFFFFFF;
			default: return $urandom();
		endcase
	endfunction

	// channel near alpha in scale, so quotients span the whole byte range
	function automatic fp_t chan_near(fp_t a);
		int e;
		e = int'(a[30:23]) - $urandom_range(0, 13);
		if ($urandom_range(0, 9) == 0) e = e + 1;
		if (e < 1) e = 1;
		if (e > 254) e = 254;
		return {1'b0, 8'(e), 23'($urandom())};
	endfunction

	task automatic random_pixel();
		fp_t a;
		if ($urandom_range(0, 99) < 75) begin
			a = {1'b0, 8'($urandom_range(100, 140)), 23'($urandom())};
			send_pixel(chan_near(a), chan_near(a), chan_near(a), a);
		end else if ($urandom_range(0, 1) == 0) begin
			send_pixel($urandom(), $urandom(), $urandom(), $urandom());
		end else begin
			a = ($urandom_range(0, 1) == 0) ? special_fp()
				: {1'b0, 8'($urandom_range(100, 140)), 23'($urandom())};
			send_pixel(special_fp(), chan_near(a), special_fp(), a);
		end
	endtask

	// returns at a falling edge once nothing is pending
	task automatic drain();
		while (pending != 0) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		red_linear = '0;
		green_linear = '0;
		blue_linear = '0;
		alpha_cover = '0;
		idle_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corner pixels: zero, one, alpha floor cases, infinities, nan, denormal
		send_pixel(32'h00000000, 32'h3F800000, 32'h3F000000, 32'h3F800000);
		send_pixel(32'h3F800000, 32'h3F800000, 32'h3F800000, 32'h3F800000);
		send_pixel(32'h3F800000, 32'h3E800000, 32'h3B4D2E1C, 32'h00000000);
		send_pixel(32'h358637BD, 32'h350637BD, 32'h340637BD, 32'hBF800000);
		send_pixel(32'h358637BD, 32'h350637BD, 32'h00000001, 32'h7FC00001);
		send_pixel(32'h358637BD, 32'h350637BD, 32'h34000000, 32'h80000000);
		send_pixel(32'h358637BD, 32'h350637BD, 32'h33000000, 32'h358637BC);
		send_pixel(32'h3F800000, 32'h7F800000, 32'h7F7FFFFF, 32'h7F800000);
		send_pixel(32'h7FC00000, 32'hFFFFFFFF, 32'h80000000, 32'h3F000000);
		send_pixel(32'h7F800000, 32'hFF800000, 32'hBF800000, 32'h3F000000);
		send_pixel(32'h007FFFFF, 32'h00000001, 32'h00400000, 32'h3F800000);
		send_pixel(32'h007FFFFF, 32'h00000001, 32'h00400000, 32'h358637BD);
		send_pixel(32'h40000000, 32'h3F7FFFFF, 32'h7F7FFFFF, 32'h3F800000);
		send_pixel(32'h3B4D2E1C, 32'h3B4D2E1D, 32'h3B4D2E1B, 32'h3F800000);
		send_pixel(32'h3A800000, 32'h3C000000, 32'h3D000000, 32'h3F800000);
		send_pixel(32'h3F7F0000, 32'h3F7FFF00, 32'h3F7F8000, 32'h3F800000);
		send_pixel(32'h7FFFFFFF, 32'h7F7FFFFF, 32'h00000000, 32'h7F7FFFFF);
		send_pixel(32'h3F800000, 32'h3F800000, 32'h3F800000, 32'hFFFFFFFF);
		send_pixel(32'h3C23D70A, 32'h3E4CCCCD, 32'h3F333333, 32'h3F4CCCCD);

		// sender pauses until every pending result is back
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: idle_pct = 0;
				1: idle_pct = 81;
				2: idle_pct = 25;
				default: idle_pct = 0;
			endcase
			repeat (300) random_pixel();
			drain();
		end

		drain();
		repeat (20) @(posedge clk);
		$display("ran %0d pixels: corner floats, alpha floor and infinity cases,", pixels_seen);
		$display("random pixels under back-to-back and sparse sender traffic");
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
